/* src/serc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket egress rule check package
// Shared types, command codes and constants for the rule check block.
// ----------------------------------------------------------------------------
package serc_pkg;

	localparam int ALLOW_DEPTH_DEF  = 64;
	localparam int REPORT_LIMIT_DEF = 32;

	localparam logic [3:0]  STATE_LISTEN = 4'hA;
	localparam logic [7:0]  LOOP_OCTET   = 8'd127;
	localparam logic [31:0] MAPPED_TAG   = 32'h0000_FFFF;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_JUDGE = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] port_value;
		logic        is_tcp;
		logic [3:0]  tcp_state;
		logic        is_v6;
		logic [63:0] remote_addr_high;
		logic [63:0] remote_addr_low;
		logic [15:0] local_port;
		logic [15:0] remote_port;
	} item_t;

	typedef struct packed {
		logic        violation;
		logic        listed;
		logic [15:0] violation_count;
		logic [6:0]  allowed_count;
	} result_t;

	typedef struct packed {
		logic load;
		logic read;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic is_judge;
		logic needs_walk;
		logic last_addr;
	} stat_t;

endpackage

/* src/serc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket egress rule check controller
// Sequences one command: capture, decision, list walk and completion.
// ----------------------------------------------------------------------------
module serc_ctrl
	import serc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output ctl_t  ctl
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		busy     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.is_judge && stat.needs_walk) begin
					state_nx = ST_WALK;
				end else begin
					ctl.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			ST_WALK: begin
				ctl.read = 1'b1;
				if (stat.last_addr) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				ctl.finish = 1'b1;
				state_nx   = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/serc_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket egress rule check datapath
// Holds the command, the allowed-port memory, the counters and the result.
// ----------------------------------------------------------------------------
module serc_dpath
	import serc_pkg::*;
#(
	parameter int ALLOW_DEPTH  = ALLOW_DEPTH_DEF,
	parameter int REPORT_LIMIT = REPORT_LIMIT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  ctl_t    ctl,
	output stat_t   stat,
	output logic    done,
	output result_t result
);

	localparam int AW = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
	localparam int CW = $clog2(ALLOW_DEPTH + 1);

	logic [15:0]   mem [ALLOW_DEPTH];
	item_t         item_q;
	logic [CW-1:0] total_q;
	logic [15:0]   count_q;
	logic [AW-1:0] raddr_q;
	logic [15:0]   rdata_s1;
	logic          rvalid_s1;
	logic          hit_q;
	logic          done_q;
	result_t       result_q;

	logic          listen;
	logic          mapped;
	logic          loop;
	logic          connected;
	logic          pass_fast;
	logic          needs_walk;
	logic          judge_viol;
	logic          total_full;
	logic          wr_en;
	logic          vflag;
	logic          lflag;
	logic [CW-1:0] total_nx;
	logic [15:0]   count_nx;

	always_comb begin
		listen = item_q.is_tcp && (item_q.tcp_state == STATE_LISTEN);
		mapped = (item_q.remote_addr_high == 64'd0)
			&& (item_q.remote_addr_low[63:32] == MAPPED_TAG);
		if (item_q.is_v6) begin
			loop = ((item_q.remote_addr_high == 64'd0) && (item_q.remote_addr_low == 64'd1))
				|| (mapped && (item_q.remote_addr_low[31:24] == LOOP_OCTET));
			connected = ((item_q.remote_addr_high | item_q.remote_addr_low) != 64'd0)
				&& (item_q.remote_port != 16'd0);
		end else begin
			loop      = item_q.remote_addr_low[31:24] == LOOP_OCTET;
			connected = (item_q.remote_addr_low[31:0] != 32'd0)
				&& (item_q.remote_port != 16'd0);
		end
		pass_fast  = listen || !connected;
		needs_walk = !pass_fast && loop && (total_q != '0);
		judge_viol = !pass_fast && !(needs_walk && hit_q);
		total_full = total_q == CW'(ALLOW_DEPTH);
	end

	always_comb begin
		stat.is_judge   = item_q.command == CMD_JUDGE;
		stat.needs_walk = needs_walk;
		stat.last_addr  = raddr_q == AW'(total_q - CW'(1));
	end

	always_comb begin
		total_nx = total_q;
		count_nx = count_q;
		wr_en    = 1'b0;
		vflag    = 1'b0;
		lflag    = 1'b0;
		unique case (cmd_e_t'(item_q.command))
			CMD_START: begin
				total_nx = '0;
				count_nx = '0;
			end
			CMD_ADD: begin
				if (!total_full) begin
					wr_en    = 1'b1;
					total_nx = total_q + CW'(1);
				end
			end
			CMD_JUDGE: begin
				if (judge_viol) begin
					vflag = 1'b1;
					lflag = count_q < 16'(REPORT_LIMIT);
					if (count_q != COUNT_MAX) begin
						count_nx = count_q + 16'd1;
					end
				end
			end
			CMD_NOP: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.finish && wr_en) begin
			mem[total_q[AW-1:0]] <= item_q.port_value;
		end
		if (ctl.read) begin
			rdata_s1 <= mem[raddr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
		end
		if (ctl.finish) begin
			result_q.violation       <= vflag;
			result_q.listed          <= lflag;
			result_q.violation_count <= count_nx;
			result_q.allowed_count   <= 7'(total_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			count_q   <= '0;
			raddr_q   <= '0;
			rvalid_s1 <= 1'b0;
			hit_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= ctl.finish;
			rvalid_s1 <= ctl.read;
			if (ctl.finish) begin
				total_q <= total_nx;
				count_q <= count_nx;
			end
			if (ctl.load) begin
				raddr_q <= '0;
			end else if (ctl.read) begin
				raddr_q <= raddr_q + AW'(1);
			end
			if (ctl.load) begin
				hit_q <= 1'b0;
			end else if (rvalid_s1 && ((rdata_s1 == item_q.local_port)
				|| (rdata_s1 == item_q.remote_port))) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* src/socket_egress_rule_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket egress rule check
// Judges sockets against an allowed-port egress rule and counts violations.
// ----------------------------------------------------------------------------
//
// Channel   Handshake          Payload    Transfer
// command   start / busy       item       edge with start high and busy low
// result    done (one cycle)   result     edge that ends the done cycle
//
// A judge of a connected, non-listening loopback socket with allowed ports
// held walks the port memory one entry a cycle over its single read port,
// then drains and finishes; other commands go from the decision state to the
// result. Reset clears the state machine and both counts; the port memory
// holds no reset value and is read only below the count. The receiver cannot
// stall, so each result is shown for one cycle.
//
module socket_egress_rule_check
	import serc_pkg::*;
#(
	parameter int ALLOW_DEPTH  = ALLOW_DEPTH_DEF,
	parameter int REPORT_LIMIT = REPORT_LIMIT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	ctl_t  ctl;
	stat_t stat;

	serc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	serc_dpath #(
		.ALLOW_DEPTH  (ALLOW_DEPTH),
		.REPORT_LIMIT (REPORT_LIMIT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

/* tb/tb_socket_egress_rule_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket egress rule check testbench
// Drives start, add, judge and other commands through start/busy and checks
// every one-cycle result against a verdict tracker that keeps its own port
// list and violation count. A directed opening covers the edge cases, random
// sessions of well-formed sequences and noise come next, and a final burst
// without idle cycles runs the violation count past the reportable limit.
// ----------------------------------------------------------------------------
module tb_socket_egress_rule_check;
	import serc_pkg::*;

	localparam int CLOCK_LIMIT  = 3_000_000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int SETTLE_WAIT  = 80;
	localparam int BURST_ITEMS  = 40;

	typedef enum int {
		SK_LISTEN,
		SK_UNCONN,
		SK_LOOP4,
		SK_LOOP6,
		SK_MAPPED,
		SK_REMOTE,
		SK_NOISE
	} sock_kind_t;

	class egress_verdict_board;
		bit [15:0]   port_list[ALLOW_DEPTH_DEF];
		int unsigned port_total;
		bit [15:0]   breach_total;
		result_t     verdicts_due[$];
		int unsigned faults;

		function bit port_held(bit [15:0] p);
			for (int i = 0; i < port_total; i++) begin
				if (port_list[i] == p)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit breaks_rule(item_t it);
			bit loop;
			bit connected;
			bit mapped;
			if (it.is_tcp && it.tcp_state == STATE_LISTEN)
				return 1'b0;
			if (it.is_v6) begin
				mapped = it.remote_addr_high == '0 && it.remote_addr_low[63:32] == MAPPED_TAG;
				loop = (it.remote_addr_high == '0 && it.remote_addr_low == 64'd1) ||
					(mapped && it.remote_addr_low[31:24] == LOOP_OCTET);
				connected = (it.remote_addr_high | it.remote_addr_low) != '0 &&
					it.remote_port != '0;
			end else begin
				loop = it.remote_addr_low[31:24] == LOOP_OCTET;
				connected = it.remote_addr_low[31:0] != '0 && it.remote_port != '0;
			end
			if (!connected)
				return 1'b0;
			if (loop && (port_held(it.local_port) || port_held(it.remote_port)))
				return 1'b0;
			return 1'b1;
		endfunction

		function void note_command(item_t it);
			result_t want;
			want = '0;
			case (cmd_e_t'(it.command))
				CMD_START: begin
					port_total = 0;
					breach_total = '0;
				end
				CMD_ADD: begin
					if (port_total < ALLOW_DEPTH_DEF) begin
						port_list[port_total] = it.port_value;
						port_total++;
					end
				end
				CMD_JUDGE: begin
					if (breaks_rule(it)) begin
						want.violation = 1'b1;
						want.listed = breach_total < REPORT_LIMIT_DEF;
						if (breach_total != COUNT_MAX)
							breach_total++;
					end
				end
				default: ;
			endcase
			want.violation_count = breach_total;
			want.allowed_count = 7'(port_total);
			verdicts_due.push_back(want);
		endfunction

		function void report(string field, longint unsigned want, longint unsigned got);
			faults++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_verdict(result_t got);
			result_t want;
			if (verdicts_due.size() == 0) begin
				faults++;
				$display("%0t: result with none expected, expected none, actual %h",
					$time, got);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.violation !== want.violation)
				report("violation", want.violation, got.violation);
			if (got.listed !== want.listed)
				report("listed", want.listed, got.listed);
			if (got.violation_count !== want.violation_count)
				report("violation_count", want.violation_count, got.violation_count);
			if (got.allowed_count !== want.allowed_count)
				report("allowed_count", want.allowed_count, got.allowed_count);
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	egress_verdict_board board;
	bit [15:0]           session_ports[$];
	int                  cycle_count;

	socket_egress_rule_check u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (done === 1'b1)
			board.check_verdict(result);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CLOCK_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("socket_egress_rule_check test failed");
		$finish;
	end

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.command          = 2'($urandom_range(0, 3));
		it.port_value       = 16'($urandom);
		it.is_tcp           = 1'($urandom);
		it.tcp_state        = 4'($urandom);
		it.is_v6            = 1'($urandom);
		it.remote_addr_high = rand64();
		it.remote_addr_low  = rand64();
		it.local_port       = 16'($urandom);
		it.remote_port      = 16'($urandom);
		return it;
	endfunction

	function automatic bit [15:0] pick_port();
		if (session_ports.size() != 0 && $urandom_range(0, 1))
			return session_ports[$urandom_range(0, session_ports.size() - 1)];
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic item_t make_socket(sock_kind_t kind);
		item_t it;
		it = noise_item();
		it.command = CMD_JUDGE;
		it.local_port = pick_port();
		it.remote_port = pick_port();
		case (kind)
			SK_LISTEN: begin
				it.is_tcp = 1'b1;
				it.tcp_state = STATE_LISTEN;
			end
			SK_UNCONN: begin
				if ($urandom_range(0, 1)) begin
					it.remote_port = '0;
				end else begin
					it.remote_addr_low[31:0] = '0;
					if (it.is_v6) begin
						it.remote_addr_high = '0;
						it.remote_addr_low = '0;
					end
				end
			end
			SK_LOOP4: begin
				it.is_v6 = 1'b0;
				it.remote_addr_low[31:24] = LOOP_OCTET;
			end
			SK_LOOP6: begin
				it.is_v6 = 1'b1;
				it.remote_addr_high = '0;
				it.remote_addr_low = 64'd1;
			end
			SK_MAPPED: begin
				it.is_v6 = 1'b1;
				it.remote_addr_high = '0;
				it.remote_addr_low[63:32] = MAPPED_TAG;
				if ($urandom_range(0, 3) != 0)
					it.remote_addr_low[31:24] = LOOP_OCTET;
			end
			SK_REMOTE: begin
				if (!it.is_v6)
					it.remote_addr_low[31:24] = 8'($urandom_range(1, 126));
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic send_command(item_t it);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		board.note_command(it);
		if (it.command == CMD_START)
			session_ports.delete();
		else if (it.command == CMD_ADD && session_ports.size() < ALLOW_DEPTH_DEF)
			session_ports.push_back(it.port_value);
	endtask

	task automatic maybe_pause(bit allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15))
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (board.verdicts_due.size() != 0);
	endtask

	initial begin
		item_t it;
		int    sent;
		int    add_count;
		int    judge_count;
		bit    pauses;
		bit    first_session;

		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening: empty list, listening, unconnected and loopback forms, extreme ports.
		it = '0;
		it.command = CMD_START;
		send_command(it);
		it = make_socket(SK_LOOP4);
		it.is_tcp = 1'b0;
		it.remote_port = 16'd80;
		send_command(it);
		send_command(make_socket(SK_LISTEN));
		it = make_socket(SK_REMOTE);
		it.is_tcp = 1'b0;
		it.tcp_state = STATE_LISTEN;
		it.remote_port = 16'hFFFF;
		send_command(it);
		it = make_socket(SK_REMOTE);
		it.is_tcp = 1'b0;
		it.is_v6 = 1'b0;
		it.remote_addr_high = '1;
		it.remote_addr_low = 64'hFFFF_FFFF_0000_0000;
		send_command(it);
		it = make_socket(SK_REMOTE);
		it.is_tcp = 1'b0;
		it.is_v6 = 1'b1;
		it.remote_addr_high = '0;
		it.remote_addr_low = '0;
		send_command(it);
		it = make_socket(SK_LOOP6);
		it.is_tcp = 1'b0;
		it.remote_port = 16'd1;
		send_command(it);
		it = '0;
		it.command = CMD_ADD;
		it.port_value = 16'h0000;
		send_command(it);
		it.port_value = 16'hFFFF;
		send_command(it);
		it.port_value = 16'd443;
		send_command(it);
		it = make_socket(SK_LOOP4);
		it.is_tcp = 1'b0;
		it.local_port = 16'd443;
		it.remote_port = 16'd5000;
		send_command(it);
		it = make_socket(SK_LOOP6);
		it.is_tcp = 1'b0;
		it.local_port = 16'd5001;
		it.remote_port = 16'hFFFF;
		send_command(it);
		it = make_socket(SK_MAPPED);
		it.is_tcp = 1'b0;
		it.remote_addr_low[31:24] = LOOP_OCTET;
		it.local_port = 16'h0000;
		it.remote_port = 16'd7;
		send_command(it);
		it.remote_addr_low[31:24] = 8'd10;
		send_command(it);
		it = '0;
		it.command = CMD_NOP;
		it.port_value = 16'd999;
		send_command(it);
		it = make_socket(SK_LOOP4);
		it.is_tcp = 1'b1;
		it.tcp_state = 4'd1;
		it.local_port = 16'd12;
		it.remote_port = 16'd13;
		send_command(it);
		it = make_socket(SK_LOOP6);
		it.is_tcp = 1'b0;
		it.remote_addr_high = 64'd1;
		it.local_port = 16'd443;
		it.remote_port = 16'd443;
		send_command(it);
		drain_results();
		repeat (5)
			@(posedge clk);

		// Random sessions: mostly start, adds, then judges; the rest is noise.
		sent = 0;
		first_session = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			pauses = $urandom_range(0, 9) < 7;
			if (first_session || $urandom_range(0, 9) < 8) begin
				it = noise_item();
				it.command = CMD_START;
				send_command(it);
				sent++;
				maybe_pause(pauses);
				if (first_session || $urandom_range(0, 9) == 0)
					add_count = $urandom_range(60, 70);
				else
					add_count = $urandom_range(0, 8);
				first_session = 1'b0;
				for (int i = 0; i < add_count; i++) begin
					it = noise_item();
					it.command = CMD_ADD;
					if ($urandom_range(0, 7) == 0)
						it.port_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					send_command(it);
					sent++;
					maybe_pause(pauses);
				end
				judge_count = $urandom_range(5, 45);
				for (int i = 0; i < judge_count; i++) begin
					send_command(make_socket(sock_kind_t'($urandom_range(0, 6))));
					sent++;
					maybe_pause(pauses);
				end
			end else begin
				repeat ($urandom_range(3, 20)) begin
					it = noise_item();
					send_command(it);
					sent++;
					maybe_pause(pauses);
				end
			end
		end
		drain_results();

		// Closing burst, no pauses: run the violation count past the listing limit.
		it = noise_item();
		it.command = CMD_START;
		send_command(it);
		for (int i = 0; i < BURST_ITEMS; i++) begin
			it = make_socket(SK_REMOTE);
			it.is_tcp = 1'b0;
			it.is_v6 = 1'b0;
			it.remote_addr_low[31:24] = 8'($urandom_range(1, 126));
			it.remote_port[0] = 1'b1;
			send_command(it);
		end
		for (int i = 0; i < 10; i++)
			send_command(make_socket(sock_kind_t'($urandom_range(0, 6))));

		drain_results();
		repeat (SETTLE_WAIT)
			@(posedge clk);
		if (board.faults == 0 && board.verdicts_due.size() == 0)
			$display("socket_egress_rule_check test passed");
		else
			$display("socket_egress_rule_check test failed");
		$finish;
	end

endmodule

/* socket_egress_rule_check.f */
src/serc_pkg.sv
src/serc_ctrl.sv
src/serc_dpath.sv
src/socket_egress_rule_check.sv
tb/tb_socket_egress_rule_check.sv
